FILE: rtl/lpr_pkg.sv
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

  localparam int unsigned PageW      = 16;
  localparam int unsigned CountW     = 16;
  localparam int unsigned FrameCfgW  = 5;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;

  localparam logic [FrameCfgW-1:0] FrameCountReset = 5'd4;
  localparam logic [CountW-1:0]    FaultMax        = '1;

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_FRAME_COUNT = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_index_e;

  // Per-cell position flags derived from occupancy and frame count.
  typedef struct packed {
    logic active;
    logic window;
    logic last;
  } cell_pos_t;

  // Controls shared by every cell of the chain.
  typedef struct packed {
    logic load;
    logic hit;
  } cell_ctrl_t;

endpackage

FILE: rtl/lpr_if.sv
// Valid/ready channel interfaces for reference and result words.
interface lpr_in_if;
  import lpr_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PageW-1:0] page_number;

  modport source (output valid, opcode, page_number, input ready);
  modport sink   (input valid, opcode, page_number, output ready);
endinterface

interface lpr_out_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              page_fault;
  logic [CountW-1:0] fault_total;
  logic              victim_valid;
  logic [PageW-1:0]  victim_page;

  modport source (output valid, page_fault, fault_total, victim_valid, victim_page,
                  input ready);
  modport sink   (input valid, page_fault, fault_total, victim_valid, victim_page,
                  output ready);
endinterface

FILE: rtl/lpr_cell.sv
// One recency position: holds a page, compares it and shifts from its neighbor.
module lpr_cell #(
  parameter int unsigned EntryW = 16
) (
  input  logic                clk_i,
  input  lpr_pkg::cell_ctrl_t ctrl_i,
  input  lpr_pkg::cell_pos_t  pos_i,
  input  logic [EntryW-1:0]   page_i,
  input  logic [EntryW-1:0]   left_i,
  input  logic                match_i,
  output logic                match_o,
  output logic [EntryW-1:0]   entry_o,
  output logic [EntryW-1:0]   victim_o
);
  import lpr_pkg::*;

  logic [EntryW-1:0] entry_q;
  logic [EntryW-1:0] entry_d;
  logic              match;
  logic              shift;

  assign match    = pos_i.active && (entry_q == page_i);
  assign match_o  = match_i || match;
  assign entry_o  = entry_q;
  assign victim_o = pos_i.last ? entry_q : '0;
  assign shift    = ctrl_i.load && (ctrl_i.hit ? !match_i : pos_i.window);
  assign entry_d  = shift ? left_i : entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: rtl/lru_page_replacement.sv
// Top level of the LRU page replacement block.
// Keeps up to MAX_FRAMES resident pages in a chain of cells ordered from most
// to least recent; each reference word is compared against every occupied
// cell at once and the chain shifts by one position in the same cycle, so one
// word is taken per clock whenever the output register is empty or being
// drained (the compare, first-match ripple and shift through the cell chain
// set that figure). The result for a word is held in that register and
// appears in the cycle after acceptance. frame_count (APB offset 0x0) selects
// how many frames are in use; zero acts as one, larger than MAX_FRAMES acts
// as MAX_FRAMES. Write it only while the block is idle.
module lru_page_replacement #(
  parameter int unsigned MAX_FRAMES = 16,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lpr_in_if.sink                        in_i,
  lpr_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lpr_pkg::ApbDataW-1:0]  pwdata,
  output logic [lpr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import lpr_pkg::*;

  localparam int unsigned OccW   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CmpW   = (OccW > FrameCfgW) ? OccW : FrameCfgW;
  localparam int unsigned EntryW = (PAGE_BITS < PageW) ? PAGE_BITS : PageW;

  logic [FrameCfgW-1:0] frame_count_q;
  logic [OccW-1:0]      occ_q, occ_d;
  logic [CountW-1:0]    fault_q, fault_d;
  logic                 out_valid_q;
  logic                 fault_flag_q, victim_valid_q;
  logic [PageW-1:0]     victim_page_q;

  logic                 accept;
  logic                 is_ref;
  logic                 cfg_write;
  logic [OccW-1:0]      cap;
  logic [OccW-1:0]      occ_eff;
  logic [OccW-1:0]      limit;
  logic                 full;
  logic                 hit;
  logic                 evict;
  logic [EntryW-1:0]    page;
  logic [EntryW-1:0]    victim;
  cell_ctrl_t           ctrl;

  logic [EntryW-1:0]    entry [MAX_FRAMES];
  logic [EntryW-1:0]    vic   [MAX_FRAMES];
  logic [MAX_FRAMES:0]  match_chain;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_FRAME_COUNT);
  assign prdata    = (paddr[2] == REG_FRAME_COUNT) ?
                     ApbDataW'(frame_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
    end else if (cfg_write) begin
      frame_count_q <= pwdata[FrameCfgW-1:0];
    end
  end

  // Effective frame count and occupancy
  always_comb begin
    if (frame_count_q == '0) begin
      cap = OccW'(1);
    end else if (CmpW'(frame_count_q) > CmpW'(MAX_FRAMES)) begin
      cap = OccW'(MAX_FRAMES);
    end else begin
      cap = OccW'(frame_count_q);
    end
  end

  assign occ_eff = (occ_q > cap) ? cap : occ_q;
  assign full    = (occ_eff == cap);
  assign limit   = full ? cap : occ_eff + OccW'(1);

  assign accept = in_i.valid && in_i.ready;
  assign is_ref = (in_i.opcode == OP_REF);
  assign page   = in_i.page_number[EntryW-1:0];

  assign ctrl.load = accept && is_ref;
  assign ctrl.hit  = hit;

  // Cell chain
  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    cell_pos_t pos;
    logic [EntryW-1:0] left;

    assign pos.active = (OccW'(i) < occ_eff);
    assign pos.window = (OccW'(i) < limit);
    assign pos.last   = (OccW'(i) == cap - OccW'(1));

    if (i == 0) begin : g_head
      assign left = page;
    end else begin : g_body
      assign left = entry[i-1];
    end

    lpr_cell #(
      .EntryW (EntryW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .pos_i    (pos),
      .page_i   (page),
      .left_i   (left),
      .match_i  (match_chain[i]),
      .match_o  (match_chain[i+1]),
      .entry_o  (entry[i]),
      .victim_o (vic[i])
    );
  end

  assign hit = match_chain[MAX_FRAMES];

  always_comb begin
    victim = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      victim = victim | vic[i];
    end
  end

  assign evict = !hit && full;

  // Occupancy and fault count
  always_comb begin
    occ_d   = occ_q;
    fault_d = fault_q;
    if (accept) begin
      if (!is_ref) begin
        occ_d   = '0;
        fault_d = '0;
      end else begin
        occ_d = (!hit && !full) ? occ_eff + OccW'(1) : occ_eff;
        if (!hit && fault_q != FaultMax) begin
          fault_d = fault_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      fault_q <= '0;
    end else begin
      occ_q   <= occ_d;
      fault_q <= fault_d;
    end
  end

  // Output register
  assign in_i.ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_flag_q   <= is_ref && !hit;
      victim_valid_q <= is_ref && evict;
      victim_page_q  <= (is_ref && evict) ? PageW'(victim) : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.page_fault   = fault_flag_q;
  assign out_o.fault_total  = fault_q;
  assign out_o.victim_valid = victim_valid_q;
  assign out_o.victim_page  = victim_page_q;

endmodule

FILE: rtl/lpr_checker.sv
// Port-level assertions for the LRU page replacement block, with its bind.
module lpr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        page_fault_i,
  input logic [lpr_pkg::CountW-1:0]  fault_total_i,
  input logic                        victim_valid_i,
  input logic [lpr_pkg::PageW-1:0]   victim_page_i
);
  import lpr_pkg::*;

  a_victim_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && victim_valid_i |-> page_fault_i)
    else $error("eviction reported without a fault");

  a_no_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !victim_valid_i |-> victim_page_i == '0)
    else $error("victim page nonzero without eviction");

  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && page_fault_i |-> fault_total_i != '0)
    else $error("fault reported with zero total");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fault_total_i)
                                && $stable(victim_page_i) && $stable(page_fault_i))
    else $error("stalled result word changed");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .page_fault_i   (out_o.page_fault),
  .fault_total_i  (out_o.fault_total),
  .victim_valid_i (out_o.victim_valid),
  .victim_page_i  (out_o.victim_page)
);

FILE: bench/tb_lru_page_replacement.sv
// Testbench for the LRU page replacement block: predicted results checked word by word.
`timescale 1ns / 100ps

module tb_lru_page_replacement;
  import lpr_pkg::*;

  localparam int unsigned MAX_FRAMES = 16;
  localparam int unsigned PAGE_BITS  = 16;

  typedef struct packed {
    logic              page_fault;
    logic [CountW-1:0] fault_total;
    logic              victim_valid;
    logic [PageW-1:0]  victim_page;
  } lookup_result_t;

  class lru_tracker;
    logic [PageW-1:0]     lru_pages [MAX_FRAMES];
    int unsigned          resident;
    logic [CountW-1:0]    faults;
    logic [FrameCfgW-1:0] frames_cfg;
    lookup_result_t       expected_words [$];

    function new();
      resident   = 0;
      faults     = '0;
      frames_cfg = FrameCountReset;
      foreach (lru_pages[i]) lru_pages[i] = '0;
    endfunction

    function void set_frames(logic [FrameCfgW-1:0] value);
      frames_cfg = value;
    endfunction

    function void note_reference(opcode_e op, logic [PageW-1:0] page);
      lookup_result_t r;
      int unsigned    cap;
      int unsigned    occ;
      int unsigned    slot;
      bit             hit;
      r = '0;
      if (op == OP_CLEAR) begin
        resident = 0;
        faults   = '0;
      end else begin
        if (frames_cfg == 0) cap = 1;
        else if (frames_cfg > MAX_FRAMES) cap = MAX_FRAMES;
        else cap = frames_cfg;
        occ  = (resident > cap) ? cap : resident;
        hit  = 1'b0;
        slot = 0;
        for (int i = 0; i < occ; i++) begin
          if (!hit && lru_pages[i] == page) begin
            hit  = 1'b1;
            slot = i;
          end
        end
        if (!hit) begin
          r.page_fault = 1'b1;
          if (occ == cap) begin
            r.victim_valid = 1'b1;
            r.victim_page  = lru_pages[cap-1];
            slot = cap - 1;
          end else begin
            slot = occ;
            occ++;
          end
          if (faults != FaultMax) faults++;
        end
        for (int i = slot; i > 0; i--) lru_pages[i] = lru_pages[i-1];
        lru_pages[0] = page;
        resident = occ;
      end
      r.fault_total = faults;
      expected_words.push_back(r);
    endfunction

    function string check_result(lookup_result_t got);
      lookup_result_t want;
      string          msg;
      if (expected_words.size() == 0) return " result word with nothing expected";
      want = expected_words.pop_front();
      msg  = "";
      if (got.page_fault !== want.page_fault)
        msg = {msg, $sformatf(" page_fault %0b want %0b", got.page_fault, want.page_fault)};
      if (got.fault_total !== want.fault_total)
        msg = {msg, $sformatf(" fault_total %0d want %0d", got.fault_total, want.fault_total)};
      if (got.victim_valid !== want.victim_valid)
        msg = {msg, $sformatf(" victim_valid %0b want %0b", got.victim_valid,
                              want.victim_valid)};
      if (got.victim_page !== want.victim_page)
        msg = {msg, $sformatf(" victim_page %h want %h", got.victim_page, want.victim_page)};
      return msg;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  lpr_in_if  in_bus ();
  lpr_out_if out_bus ();

  lru_tracker  sb;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  bit          tx_gaps = 1'b0;
  bit          rx_gaps = 1'b0;

  lru_page_replacement #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("ERROR at %0t:%s", $time, msg);
  endtask

  task automatic send_word(opcode_e op, logic [PageW-1:0] page);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= op;
    in_bus.page_number <= page;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_reference(op, page);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_index_e idx, logic [FrameCfgW-1:0] value);
    logic [ApbDataW-1:0] data;
    data = $urandom();
    data[FrameCfgW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(4 * int'(idx));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_COUNT) sb.set_frames(value);
  endtask

  task automatic run_phase(logic [FrameCfgW-1:0] setting, int unsigned count);
    int unsigned      cap;
    int unsigned      pool;
    int unsigned      roll;
    logic [PageW-1:0] base;
    write_reg(REG_FRAME_COUNT, setting);
    if ($urandom_range(2, 0) == 0) write_reg(REG_UNUSED, FrameCfgW'($urandom()));
    if (setting == 0) cap = 1;
    else if (setting > MAX_FRAMES) cap = MAX_FRAMES;
    else cap = setting;
    pool    = cap + 1 + $urandom_range(3, 0);
    base    = PageW'($urandom());
    tx_gaps = ($urandom_range(3, 0) != 0);
    rx_gaps = ($urandom_range(3, 0) != 0);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99, 0);
      if (roll < 4) send_word(OP_CLEAR, PageW'($urandom()));
      else if (roll < 14) send_word(OP_REF, PageW'($urandom()));
      else send_word(OP_REF, base + PageW'($urandom_range(pool - 1, 0)));
    end
    settle();
  endtask

  initial begin
    lookup_result_t got;
    int unsigned    stall;
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = rx_gaps ? $urandom_range(7, 0) : 0;
      if (results_seen % 400 == 137) stall = 48 + $urandom_range(32, 0);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got.page_fault   = out_bus.page_fault;
      got.fault_total  = out_bus.fault_total;
      got.victim_valid = out_bus.victim_valid;
      got.victim_page  = out_bus.victim_page;
      results_seen++;
      begin
        string msg;
        msg = sb.check_result(got);
        if (msg != "") report_mismatch(msg);
      end
    end
  end

  initial begin
    #1200000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb = new();
    in_bus.valid       <= 1'b0;
    in_bus.opcode      <= OP_REF;
    in_bus.page_number <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset frame count of four: fill, evict, hit in the middle and at the old end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_word(OP_REF, 16'h0000);
    send_word(OP_REF, 16'hFFFF);
    send_word(OP_REF, 16'h0000);
    send_word(OP_REF, 16'h1234);
    send_word(OP_REF, 16'h8001);
    send_word(OP_REF, 16'h4321);
    send_word(OP_REF, 16'h1234);
    send_word(OP_REF, 16'h0000);
    send_word(OP_CLEAR, 16'hFFFF);
    send_word(OP_REF, 16'h0000);
    send_word(OP_REF, 16'h0000);
    send_word(OP_CLEAR, 16'h0000);
    settle();

    write_reg(REG_FRAME_COUNT, 5'd1);
    send_word(OP_REF, 16'h0007);
    send_word(OP_REF, 16'h0007);
    send_word(OP_REF, 16'h0009);
    settle();
    write_reg(REG_UNUSED, 5'd31);
    send_word(OP_REF, 16'h0007);
    settle();
    write_reg(REG_FRAME_COUNT, 5'd0);
    send_word(OP_REF, 16'h0009);
    send_word(OP_REF, 16'h0009);
    settle();

    // back-to-back references at full rate
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_word(OP_CLEAR, 16'h0000);
    for (int n = 0; n < 40; n++) send_word(OP_REF, n[0] ? 16'h5555 : 16'hAAAA);
    send_word(OP_REF, 16'h5555);
    send_word(OP_CLEAR, 16'h0000);
    settle();

    // full list of sixteen, then shrink without a clear
    run_phase(5'd16, 120);
    run_phase(5'd3, 110);
    run_phase(5'd31, 110);
    run_phase(5'd0, 110);
    run_phase(5'd8, 110);
    run_phase(5'd1, 110);
    run_phase(5'd17, 110);
    run_phase(5'd5, 110);
    run_phase(FrameCfgW'($urandom()), 120);
    run_phase(5'd2, 110);
    run_phase(FrameCfgW'($urandom()), 120);

    repeat (8) @(posedge clk_i);
    if (sb.expected_words.size() != 0)
      report_mismatch($sformatf(" %0d expected words never arrived",
                                sb.expected_words.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
